/* sv/length_prefixed_message_deframer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed message deframer
// Shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define LPMD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lpmd_pkg.sv */
// ----------------------------------------------------------------------------
// lpmd_pkg
// Constants, types and helper functions of the message deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

	// header storage
	localparam int HEADER_MAX = 16;
	localparam int HDR_AW = (HEADER_MAX > 1) ? $clog2(HEADER_MAX) : 1;
	localparam int HDR_CW = $clog2(HEADER_MAX + 1);

	// length field
	localparam int LENGTH_MAX_BYTES = 4;
	localparam int LEN_W = 32;
	localparam int LW_W = 3;

	// register and field widths
	localparam int BYTE_W = 8;
	localparam int HS_W = 5;
	localparam int OFF_W = 4;
	localparam int LB_W = 3;
	localparam int MAX_W = 24;
	localparam int ASUM_W = ((HDR_AW > OFF_W) ? HDR_AW : OFF_W) + 1;

	// register reset values
	localparam logic [HS_W-1:0] RST_HEADER_SIZE = HS_W'(4);
	localparam logic [OFF_W-1:0] RST_LENGTH_OFFSET = OFF_W'(0);
	localparam logic [LB_W-1:0] RST_LENGTH_BYTES = LB_W'(4);
	localparam logic [MAX_W-1:0] RST_MAX_BODY = MAX_W'(1024);

	// register map
	localparam int REG_IW = 2;
	localparam int APB_AW = REG_IW + 2;
	localparam int APB_DW = 32;
	localparam logic [REG_IW-1:0] REG_HEADER_SIZE = REG_IW'(0);
	localparam logic [REG_IW-1:0] REG_LENGTH_OFFSET = REG_IW'(1);
	localparam logic [REG_IW-1:0] REG_LENGTH_BYTES = REG_IW'(2);
	localparam logic [REG_IW-1:0] REG_MAX_BODY = REG_IW'(3);

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_LW = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [HS_W-1:0] header_size;
		logic [OFF_W-1:0] length_offset;
		logic [LB_W-1:0] length_bytes;
		logic [MAX_W-1:0] max_body;
	} cfg_t;

	typedef struct packed {
		logic psel;
		logic penable;
		logic pwrite;
		logic [APB_AW-1:0] paddr;
		logic [APB_DW-1:0] pwdata;
	} apb_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic first;
		logic last;
		logic oversize_error;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} q_push_t;

	// header size clamped to 1..HEADER_MAX
	function automatic logic [HDR_CW-1:0] eff_hsize(input logic [HS_W-1:0] hs);
		int h;
		h = int'(hs);
		if (h < 1) h = 1;
		if (h > HEADER_MAX) h = HEADER_MAX;
		return HDR_CW'(h);
	endfunction

	// length field width in bytes, zero when there is no usable field
	function automatic logic [LW_W-1:0] eff_lwidth(
		input logic [HDR_CW-1:0] hs,
		input logic [OFF_W-1:0] off,
		input logic [LB_W-1:0] lb
	);
		int w;
		int h;
		w = int'(lb);
		h = int'(hs);
		if (w > LENGTH_MAX_BYTES) w = LENGTH_MAX_BYTES;
		if (w > h) w = h;
		if (w == 3) w = 4;
		if (w > 4) w = 4;
		if (w == 0) return '0;
		if (int'(off) + w > h) return '0;
		return LW_W'(w);
	endfunction

endpackage

`default_nettype wire

/* sv/lpmd_if.sv */
// ----------------------------------------------------------------------------
// lpmd_if
// Valid/ready channels of the deframer: raw byte input, message item output
// ----------------------------------------------------------------------------
`default_nettype none

interface lpmd_in_if;
	logic valid;
	logic ready;
	logic [lpmd_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lpmd_out_if;
	logic valid;
	logic ready;
	logic [lpmd_pkg::BYTE_W-1:0] out_byte;
	logic first;
	logic last;
	logic oversize_error;

	modport source (output valid, output out_byte, output first, output last,
		output oversize_error, input ready);
	modport sink (input valid, input out_byte, input first, input last,
		input oversize_error, output ready);
endinterface

`default_nettype wire

/* sv/lpmd_cfg.sv */
// ----------------------------------------------------------------------------
// lpmd_cfg
// APB register file: header size, length offset, length width, max body
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpmd_pkg::apb_req_t                  apb,
	output logic [lpmd_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,
	output lpmd_pkg::cfg_t                      cfg
);

	lpmd_pkg::cfg_t cfg_q;
	logic wr;
	logic [lpmd_pkg::REG_IW-1:0] idx;

	assign pready = 1'b1;
	assign wr = apb.psel && apb.penable && apb.pwrite;
	assign idx = apb.paddr[lpmd_pkg::APB_AW-1:2];
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_size <= lpmd_pkg::RST_HEADER_SIZE;
			cfg_q.length_offset <= lpmd_pkg::RST_LENGTH_OFFSET;
			cfg_q.length_bytes <= lpmd_pkg::RST_LENGTH_BYTES;
			cfg_q.max_body <= lpmd_pkg::RST_MAX_BODY;
		end else if (wr) begin
			unique case (idx)
				lpmd_pkg::REG_HEADER_SIZE: begin
					cfg_q.header_size <= apb.pwdata[lpmd_pkg::HS_W-1:0];
				end
				lpmd_pkg::REG_LENGTH_OFFSET: begin
					cfg_q.length_offset <= apb.pwdata[lpmd_pkg::OFF_W-1:0];
				end
				lpmd_pkg::REG_LENGTH_BYTES: begin
					cfg_q.length_bytes <= apb.pwdata[lpmd_pkg::LB_W-1:0];
				end
				lpmd_pkg::REG_MAX_BODY: begin
					cfg_q.max_body <= apb.pwdata[lpmd_pkg::MAX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			lpmd_pkg::REG_HEADER_SIZE: prdata = lpmd_pkg::APB_DW'(cfg_q.header_size);
			lpmd_pkg::REG_LENGTH_OFFSET: prdata = lpmd_pkg::APB_DW'(cfg_q.length_offset);
			lpmd_pkg::REG_LENGTH_BYTES: prdata = lpmd_pkg::APB_DW'(cfg_q.length_bytes);
			lpmd_pkg::REG_MAX_BODY: prdata = lpmd_pkg::APB_DW'(cfg_q.max_body);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* sv/lpmd_outq.sv */
// ----------------------------------------------------------------------------
// lpmd_outq
// Small output queue that decouples message items from the downstream side
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_message_deframer_macros.svh"

module lpmd_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpmd_pkg::q_push_t             push,
	output logic [lpmd_pkg::OQ_LW-1:0]    level,
	lpmd_out_if.source                    tx
);

	lpmd_pkg::item_t q_mem [lpmd_pkg::OQ_DEPTH];
	logic [lpmd_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [lpmd_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [lpmd_pkg::OQ_LW-1:0] level_q;
	logic pop;
	lpmd_pkg::item_t head;

	assign level = level_q;
	assign pop = tx.valid && tx.ready;
	assign head = q_mem[rd_ptr_q];

	// head item to the output channel
	assign tx.valid = (level_q != '0);
	assign tx.out_byte = head.out_byte;
	assign tx.first = head.first;
	assign tx.last = head.last;
	assign tx.oversize_error = head.oversize_error;

	// queue storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			q_mem[wr_ptr_q] <= push.item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == lpmd_pkg::OQ_AW'(lpmd_pkg::OQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + lpmd_pkg::OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lpmd_pkg::OQ_AW'(lpmd_pkg::OQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + lpmd_pkg::OQ_AW'(1);
			end
			level_q <= level_q + lpmd_pkg::OQ_LW'(push.valid) - lpmd_pkg::OQ_LW'(pop);
		end
	end

	`LPMD_ASSERT_IMPL(a_level_range, 1'b1, level_q <= lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH), "queue level out of range")
	`LPMD_ASSERT_IMPL(a_ptr_match, wr_ptr_q == rd_ptr_q, level_q == '0 || level_q == lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH), "pointers equal with queue partly filled")
	`LPMD_ASSERT_IMPL(a_no_overflow, push.valid && !pop, level_q < lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH), "push into a full queue")

endmodule

`default_nettype wire

/* sv/lpmd_ctrl.sv */
// ----------------------------------------------------------------------------
// lpmd_ctrl
// Header RAM and framing sequencer: collects header bytes, reads the length
// field back from the RAM, checks it and replays the header (or pushes one
// oversize_error item in its place), then passes body
`default_nettype none

`include "length_prefixed_message_deframer_macros.svh"

module lpmd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpmd_pkg::cfg_t                cfg,
	input  logic [lpmd_pkg::OQ_LW-1:0]    q_level,
	output lpmd_pkg::q_push_t             push,
	lpmd_in_if.sink                       rx
);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_REPLAY = 2'd3;

	// header RAM
	logic [lpmd_pkg::BYTE_W-1:0] hdr_mem [lpmd_pkg::HEADER_MAX];
	logic hdr_we;
	logic [lpmd_pkg::HDR_AW-1:0] wr_addr;
	logic rd_en;
	logic [lpmd_pkg::HDR_AW-1:0] rd_addr;
	logic [lpmd_pkg::BYTE_W-1:0] rd_data_s1;

	// framing state
	logic [1:0] st_q;
	logic [lpmd_pkg::HDR_CW-1:0] hdr_cnt_q;
	logic in_body_q;
	logic [lpmd_pkg::MAX_W-1:0] body_rem_q;
	logic [lpmd_pkg::LEN_W-1:0] len_q;
	logic [lpmd_pkg::LW_W-1:0] lidx_q;
	logic [lpmd_pkg::HDR_CW-1:0] ridx_q;
	logic lrd_s1;
	logic rrd_s1;
	logic first_s1;
	logic last_s1;

	logic [lpmd_pkg::HDR_CW-1:0] hs_eff;
	logic [lpmd_pkg::LW_W-1:0] lw_eff;
	logic [lpmd_pkg::HDR_CW-1:0] cnt_inc;
	logic [lpmd_pkg::ASUM_W-1:0] laddr_sum;
	logic accept;
	logic hdr_done;
	logic q_space;
	logic oversize;

	assign hs_eff = lpmd_pkg::eff_hsize(cfg.header_size);
	assign lw_eff = lpmd_pkg::eff_lwidth(hs_eff, cfg.length_offset, cfg.length_bytes);

	// input handshake
	assign rx.ready = (st_q == ST_COLLECT) &&
		(!in_body_q || q_level < lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH));
	assign accept = rx.valid && rx.ready;
	assign cnt_inc = hdr_cnt_q + lpmd_pkg::HDR_CW'(1);
	assign hdr_done = cnt_inc >= hs_eff;

	// queue room, counting a replay read still in flight
	assign q_space = (q_level + lpmd_pkg::OQ_LW'(rrd_s1)) <
		lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH);
	assign oversize = len_q > lpmd_pkg::LEN_W'(cfg.max_body);

	// RAM write and read port selection
	assign hdr_we = accept && !in_body_q &&
		(hdr_cnt_q < lpmd_pkg::HDR_CW'(lpmd_pkg::HEADER_MAX));
	assign wr_addr = hdr_cnt_q[lpmd_pkg::HDR_AW-1:0];
	assign laddr_sum = lpmd_pkg::ASUM_W'(cfg.length_offset) + lpmd_pkg::ASUM_W'(lidx_q);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = ridx_q[lpmd_pkg::HDR_AW-1:0];
		unique case (st_q)
			ST_LEN: begin
				rd_en = lidx_q < lw_eff;
				rd_addr = laddr_sum[lpmd_pkg::HDR_AW-1:0];
			end
			ST_REPLAY: begin
				rd_en = (ridx_q < hs_eff) && q_space;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[wr_addr] <= rx.in_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= hdr_mem[rd_addr];
		end
	end

	// item pushed to the output queue
	always_comb begin
		push.valid = 1'b0;
		push.item.out_byte = rx.in_byte;
		push.item.first = 1'b0;
		push.item.last = body_rem_q <= lpmd_pkg::MAX_W'(1);
		push.item.oversize_error = 1'b0;
		priority if (rrd_s1) begin
			push.valid = 1'b1;
			push.item.out_byte = rd_data_s1;
			push.item.first = first_s1;
			push.item.last = last_s1;
		end else if (st_q == ST_CHECK && oversize) begin
			push.valid = q_space;
			push.item.out_byte = '0;
			push.item.last = 1'b0;
			push.item.oversize_error = 1'b1;
		end else if (st_q == ST_COLLECT && accept && in_body_q) begin
			push.valid = 1'b1;
		end else begin
			push.valid = 1'b0;
		end
	end

	// framing sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_COLLECT;
			hdr_cnt_q <= '0;
			in_body_q <= 1'b0;
			body_rem_q <= '0;
			len_q <= '0;
			lidx_q <= '0;
			ridx_q <= '0;
			lrd_s1 <= 1'b0;
			rrd_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			lrd_s1 <= rd_en && (st_q == ST_LEN);
			rrd_s1 <= rd_en && (st_q == ST_REPLAY);
			first_s1 <= ridx_q == '0;
			last_s1 <= (len_q == '0) && (ridx_q == hs_eff - lpmd_pkg::HDR_CW'(1));
			unique case (st_q)
				ST_COLLECT: begin
					if (accept) begin
						if (in_body_q) begin
							body_rem_q <= body_rem_q - lpmd_pkg::MAX_W'(1);
							if (body_rem_q <= lpmd_pkg::MAX_W'(1)) in_body_q <= 1'b0;
						end else if (hdr_done) begin
							hdr_cnt_q <= '0;
							lidx_q <= '0;
							len_q <= '0;
							st_q <= ST_LEN;
						end else begin
							hdr_cnt_q <= cnt_inc;
						end
					end
				end
				ST_LEN: begin
					// big-endian accumulate as bytes return
					if (lrd_s1) begin
						len_q <= (len_q << lpmd_pkg::BYTE_W) | lpmd_pkg::LEN_W'(rd_data_s1);
					end
					if (lidx_q < lw_eff) begin
						lidx_q <= lidx_q + lpmd_pkg::LW_W'(1);
					end else if (!lrd_s1) begin
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (oversize) begin
						if (q_space) st_q <= ST_COLLECT;
					end else begin
						ridx_q <= '0;
						st_q <= ST_REPLAY;
					end
				end
				ST_REPLAY: begin
					if (rd_en) begin
						ridx_q <= ridx_q + lpmd_pkg::HDR_CW'(1);
					end else if (ridx_q == hs_eff && !rrd_s1) begin
						if (len_q != '0) begin
							in_body_q <= 1'b1;
							body_rem_q <= lpmd_pkg::MAX_W'(len_q);
						end
						st_q <= ST_COLLECT;
					end
				end
				default: begin
					st_q <= ST_COLLECT;
				end
			endcase
		end
	end

	`LPMD_ASSERT_IMPL(a_push_room, push.valid, q_level < lpmd_pkg::OQ_LW'(lpmd_pkg::OQ_DEPTH), "item pushed with output queue full")
	`LPMD_ASSERT_IMPL(a_body_count, in_body_q, body_rem_q != '0, "body phase with nothing left to pass")
	`LPMD_ASSERT_IMPL(a_collect_clean, st_q == ST_COLLECT, hdr_cnt_q < lpmd_pkg::HDR_CW'(lpmd_pkg::HEADER_MAX) && !rrd_s1, "header count overrun or replay read left over")
	`LPMD_ASSERT_NEXT(a_hdr_to_len, st_q == ST_COLLECT && accept && !in_body_q && hdr_done, st_q == ST_LEN && lidx_q == '0 && hdr_cnt_q == '0, "header completion did not start length read")

endmodule

`default_nettype wire

/* sv/length_prefixed_message_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Cuts a byte stream into header-plus-body messages
// ----------------------------------------------------------------------------
// Each input item is one stream byte. Header bytes are written to a 16-entry
// header RAM and produce no output until the header is complete; the length
// field is then read back one byte per cycle through the RAM's single read
// port, checked against max_body, and the header is replayed from the RAM
// (first byte marked) or replaced by one oversize_error item. Body bytes then
// pass through a 4-entry output queue, the last one marked. Header and body
// bytes are taken at one item per cycle, body bytes only while the output
// queue has room; after the byte that completes a header, input pauses while
// the RAM read port serves the length read and the header replay, or the
// oversize_error item is queued, longer whenever the output side stalls.
// Registers are written over APB at byte address 4*index.
`default_nettype none

module length_prefixed_message_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpmd_pkg::APB_AW-1:0]       paddr,
	input  logic [lpmd_pkg::APB_DW-1:0]       pwdata,
	output logic [lpmd_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	lpmd_in_if.sink                           rx,
	lpmd_out_if.source                        tx
);

	lpmd_pkg::apb_req_t apb;
	lpmd_pkg::cfg_t cfg;
	lpmd_pkg::q_push_t push;
	logic [lpmd_pkg::OQ_LW-1:0] q_level;

	// bundle the APB request
	assign apb.psel = psel;
	assign apb.penable = penable;
	assign apb.pwrite = pwrite;
	assign apb.paddr = paddr;
	assign apb.pwdata = pwdata;

	lpmd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.apb    (apb),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lpmd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_level (q_level),
		.push    (push),
		.rx      (rx)
	);

	lpmd_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (q_level),
		.tx     (tx)
	);

endmodule

`default_nettype wire
